// ===== hw/rtl/graph_component_finder_defines.svh =====
// Assertion macros shared by the graph component finder RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef GRAPH_COMPONENT_FINDER_DEFINES_SVH
`define GRAPH_COMPONENT_FINDER_DEFINES_SVH

`ifndef ASSERT_OFF

// Condition that must hold at every clock edge out of reset.
`define GCF_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define GCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define GCF_ASSERT_ALWAYS(lbl, expr, msg)
`define GCF_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/gcf_pkg.sv =====
// Shared constants, types and helper functions of the graph component finder.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gcf_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int VIDX_W       = 5;
  localparam int MASK_W       = MAX_VERTICES;
  localparam int CNT_W        = 6;

  typedef enum logic [1:0] {
    REQ_ARC    = 2'd0,
    REQ_STRONG = 2'd1,
    REQ_WEAK   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef logic [VIDX_W-1:0] vidx_t;
  typedef logic [MASK_W-1:0] vmask_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;         // capture an accepted item
    logic arc_rd;       // read row a and column b
    logic arc_wr;       // write back row a and column b with the new arc
    logic search_init;  // seed the visited set with the query vertex
    logic init_row;     // follow arcs forward in the new search
    logic init_col;     // follow arcs backward in the new search
    logic search_step;  // expand one vertex and merge the previous read
    logic save_fwd;     // keep the forward set of a strong query
    logic out_load;     // load the result register
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    req_t req;
    logic err;
    logic search_idle;
  } dp_stat_t;

  function automatic vidx_t lowest_index(vmask_t m);
    vidx_t idx;
    idx = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = vidx_t'(i);
      end
    end
    return idx;
  endfunction

  function automatic vmask_t onehot(vidx_t v);
    return vmask_t'(1) << v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gcf_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module gcf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gcf_dpath.sv =====
// Datapath: arc and column memories, row and column valid bits, search sets, result register.
// Depends on gcf_pkg and gcf_ram.
`timescale 1ns / 1ps
`default_nettype none

module gcf_dpath import gcf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  input  logic [1:0]       in_req_type,
  input  vidx_t            in_vertex_a,
  input  vidx_t            in_vertex_b,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  output vmask_t           out_member_mask,
  output logic             out_range_error
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] n_w;
  logic [MASK_W:0]  live_w;
  logic             in_a_ok;
  logic             in_b_ok;
  logic             err_in;

  req_t   req_r;
  vidx_t  va_r;
  vidx_t  vb_r;
  logic   err_r;
  vmask_t live_r;
  vmask_t set_r, set_nxt;
  vmask_t done_r, done_nxt;
  logic   pend_r, pend_nxt;
  vmask_t fwd_r;
  logic   use_row_r;
  logic   use_col_r;
  logic   row_vq_r;
  logic   col_vq_r;
  vmask_t row_valid_r;
  vmask_t col_valid_r;
  vmask_t mask_out_r;
  logic   err_out_r;

  vmask_t row_rdata;
  vmask_t col_rdata;
  vmask_t row_q;
  vmask_t col_q;
  vmask_t merge;
  vmask_t frontier;
  vidx_t  pick;
  vidx_t  row_raddr;
  vidx_t  col_raddr;
  vmask_t result;

  // Clamp the count to the matrix size and range check the incoming item.
  assign n_w     = (count_r > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : count_r;
  assign live_w  = ((MASK_W+1)'(1) << n_w) - (MASK_W+1)'(1);
  assign in_a_ok = {1'b0, in_vertex_a} < n_w;
  assign in_b_ok = {1'b0, in_vertex_b} < n_w;

  always_comb begin
    unique case (req_t'(in_req_type))
      REQ_ARC:    err_in = !(in_a_ok && in_b_ok);
      REQ_STRONG: err_in = !in_a_ok;
      REQ_WEAK:   err_in = !in_a_ok;
      REQ_NONE:   err_in = 1'b0;
    endcase
  end

  // Rows and columns never written read as empty.
  assign row_q    = row_rdata & {MASK_W{row_vq_r}};
  assign col_q    = col_rdata & {MASK_W{col_vq_r}};
  assign merge    = ((use_row_r ? row_q : '0) | (use_col_r ? col_q : '0)) & live_r;
  assign frontier = set_r & ~done_r;
  assign pick     = lowest_index(frontier);

  assign row_raddr = cmd.arc_rd ? va_r : pick;
  assign col_raddr = cmd.arc_rd ? vb_r : pick;

  gcf_ram #(.WIDTH(MASK_W), .DEPTH(MAX_VERTICES)) u_row_ram (
    .clk   (clk),
    .we    (cmd.arc_wr),
    .waddr (va_r),
    .wdata (row_q | onehot(vb_r)),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  gcf_ram #(.WIDTH(MASK_W), .DEPTH(MAX_VERTICES)) u_col_ram (
    .clk   (clk),
    .we    (cmd.arc_wr),
    .waddr (vb_r),
    .wdata (col_q | onehot(va_r)),
    .raddr (col_raddr),
    .rdata (col_rdata)
  );

  // Worklist search: issue the lowest unexpanded vertex, merge its row, column or both next cycle.
  always_comb begin
    set_nxt  = set_r;
    done_nxt = done_r;
    pend_nxt = pend_r;
    if (cmd.search_init) begin
      set_nxt  = onehot(va_r);
      done_nxt = '0;
      pend_nxt = 1'b0;
    end else if (cmd.search_step) begin
      if (pend_r) begin
        set_nxt = set_r | merge;
      end
      pend_nxt = (frontier != '0);
      if (frontier != '0) begin
        done_nxt[pick] = 1'b1;
      end
    end
  end

  always_comb begin
    if (err_r) begin
      result = '0;
    end else begin
      unique case (req_r)
        REQ_STRONG: result = fwd_r & set_r;
        REQ_WEAK:   result = set_r;
        REQ_ARC:    result = '0;
        REQ_NONE:   result = '0;
      endcase
    end
  end

  assign stat.req         = req_r;
  assign stat.err         = err_r;
  assign stat.search_idle = (frontier == '0) && !pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= CNT_W'(MAX_VERTICES);
      row_valid_r <= '0;
      col_valid_r <= '0;
      pend_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        count_r <= cfg_wr_data;
      end
      if (cmd.arc_wr) begin
        row_valid_r[va_r] <= 1'b1;
        col_valid_r[vb_r] <= 1'b1;
      end
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_vq_r <= row_valid_r[row_raddr];
    col_vq_r <= col_valid_r[col_raddr];
    set_r    <= set_nxt;
    done_r   <= done_nxt;
    if (cmd.load) begin
      req_r  <= req_t'(in_req_type);
      va_r   <= in_vertex_a;
      vb_r   <= in_vertex_b;
      err_r  <= err_in;
      live_r <= live_w[MASK_W-1:0];
    end
    if (cmd.search_init) begin
      use_row_r <= cmd.init_row;
      use_col_r <= cmd.init_col;
    end
    if (cmd.save_fwd) begin
      fwd_r <= set_r;
    end
    if (cmd.out_load) begin
      mask_out_r <= result;
      err_out_r  <= err_r;
    end
  end

  assign out_member_mask = mask_out_r;
  assign out_range_error = err_out_r;

endmodule

`default_nettype wire

// ===== hw/rtl/gcf_ctrl.sv =====
// Controller: sequences arc updates, searches and result hand-off.
// Depends on gcf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcf_ctrl import gcf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ARC_RD,
    S_ARC_WR,
    S_SEARCH,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   phase_bwd_r, phase_bwd_nxt;

  always_comb begin
    state_nxt     = state_r;
    phase_bwd_nxt = phase_bwd_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        phase_bwd_nxt = 1'b0;
        if (stat.err) begin
          state_nxt = S_FINISH;
        end else begin
          unique case (stat.req)
            REQ_ARC: state_nxt = S_ARC_RD;
            REQ_STRONG: begin
              cmd.search_init = 1'b1;
              cmd.init_row    = 1'b1;
              state_nxt       = S_SEARCH;
            end
            REQ_WEAK: begin
              cmd.search_init = 1'b1;
              cmd.init_row    = 1'b1;
              cmd.init_col    = 1'b1;
              state_nxt       = S_SEARCH;
            end
            REQ_NONE: state_nxt = S_FINISH;
          endcase
        end
      end
      S_ARC_RD: begin
        cmd.arc_rd = 1'b1;
        state_nxt  = S_ARC_WR;
      end
      S_ARC_WR: begin
        cmd.arc_wr = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_SEARCH: begin
        cmd.search_step = 1'b1;
        if (stat.search_idle) begin
          if (stat.req == REQ_STRONG && !phase_bwd_r) begin
            // Forward pass done: keep it, run the backward pass.
            cmd.save_fwd    = 1'b1;
            cmd.search_init = 1'b1;
            cmd.init_col    = 1'b1;
            phase_bwd_nxt   = 1'b1;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      phase_bwd_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      phase_bwd_r <= phase_bwd_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== hw/rtl/graph_component_finder.sv =====
// Top level of the graph component finder: controller plus datapath.
// Depends on gcf_pkg, gcf_ctrl, gcf_dpath and graph_component_finder_defines.svh.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------------
//   in_     | input     | in_valid / in_stall | in_req_type, in_vertex_a, in_vertex_b
//   out_    | output    | out_valid/out_stall | out_member_mask, out_range_error
//   cfg_    | input     | cfg_wr_en           | cfg_wr_data (vertex_count)
//
// One item at a time; the next input transfer is taken in the cycle after the result
// loads. Rejected or unknown items go from the check straight to the result; an add
// arc first does a row and column read-modify-write. A search expands vertices from
// a worklist (a chain of arcs costs a read bubble per vertex), so a weak query runs
// one search over arcs both ways and a strong query a forward then a backward search.
// Reset clears the arc matrix at once through per-row and per-column valid bits; no sweep.
// A stalled result sits in the output register while the next item is taken in.
`timescale 1ns / 1ps
`default_nettype none
`include "graph_component_finder_defines.svh"

module graph_component_finder import gcf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_req_type,
  input  logic [4:0]       in_vertex_a,
  input  logic [4:0]       in_vertex_b,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [31:0]      out_member_mask,
  output logic             out_range_error
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     err_mask_ok;

  // Sequencer: accepts items, drives the datapath, owns out_valid.
  gcf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Arc storage, visited sets and the result register.
  gcf_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_req_type     (in_req_type),
    .in_vertex_a     (in_vertex_a),
    .in_vertex_b     (in_vertex_b),
    .cmd             (cmd),
    .stat            (stat),
    .out_member_mask (out_member_mask),
    .out_range_error (out_range_error)
  );

  assign err_mask_ok = !(out_valid && out_range_error) || (out_member_mask == '0);

  // A rejected item never reports members.
  `GCF_ASSERT_ALWAYS(a_err_empty, err_mask_ok, "range error with nonzero mask")
  // The result register is never overwritten while a held result waits.
  `GCF_ASSERT_ALWAYS(a_no_overwrite, !(cmd.out_load && out_valid && out_stall), "held result overwritten")
  // After a transfer in, the block stays busy until the item is done.
  `GCF_ASSERT_NEXT(a_busy_after_load, cmd.load, in_stall, "input open right after a transfer")

endmodule

`default_nettype wire

// ===== bench/tb_graph_component_finder.sv =====
// Self-checking testbench for graph_component_finder: arc adds, strong and weak
// component queries under random idling, back-pressure and vertex_count changes.
// Depends on gcf_pkg and the graph_component_finder RTL.
`timescale 1ns / 1ps

module tb_graph_component_finder;
  import gcf_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  // Quiet cycles after the last result before the next phase starts.
  localparam int SETTLE      = 80;
  localparam int LONG_HOLD   = 300;

  typedef struct packed {
    req_t  req;
    vidx_t a;
    vidx_t b;
  } item_t;

  typedef struct packed {
    vmask_t mask;
    logic   err;
  } result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [CNT_W-1:0] cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       in_req_type = '0;
  logic [4:0]       in_vertex_a = '0;
  logic [4:0]       in_vertex_b = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [31:0]      out_member_mask;
  logic             out_range_error;

  graph_component_finder uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_vertex_a     (in_vertex_a),
    .in_vertex_b     (in_vertex_b),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_member_mask (out_member_mask),
    .out_range_error (out_range_error)
  );

  always #1 clk = ~clk;

  // Shadow copy of the block's graph and register. The arc matrix is only
  // touched at transfer time, the count only while the block is idle.
  vmask_t           adj_rows [MAX_VERTICES];
  logic [CNT_W-1:0] vert_count = CNT_W'(32);

  item_t   pending_items[$];
  result_t expected_results[$];

  // Per-phase knobs set by the sequencer; hold_ack belongs to the result monitor.
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_req   = 1'b0;
  bit hold_ack   = 1'b0;

  int fail_count    = 0;
  int cycle_count   = 0;
  int results_seen  = 0;
  int cnt_arc       = 0;
  int cnt_strong    = 0;
  int cnt_weak      = 0;
  int cnt_unknown   = 0;
  int cnt_rejected  = 0;
  int cfg_writes    = 0;

  int tx_gap_left   = 0;
  int rx_stall_left = 0;
  int rx_hold_left  = 0;

  // Append to the tail of the pending and expected queues.
  function automatic void add_pending(item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic void add_expected(result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int active_vertices();
    return (vert_count > CNT_W'(MAX_VERTICES)) ? MAX_VERTICES : int'(vert_count);
  endfunction

  // Fixed-point closure from one vertex over the first lim vertices, following
  // arcs forward, backward or both.
  function automatic vmask_t reach_set(int start, int lim, bit fwd, bit bwd);
    vmask_t live;
    vmask_t cur;
    vmask_t seen;
    live = (lim >= MAX_VERTICES) ? '1 : vmask_t'((64'd1 << lim) - 64'd1);
    cur  = vmask_t'(1) << start;
    seen = '0;
    while (cur != seen) begin
      seen = cur;
      for (int v = 0; v < lim; v++) begin
        if (fwd && seen[v]) cur |= adj_rows[v] & live;
        if (bwd && ((adj_rows[v] & seen) != '0)) cur[v] = 1'b1;
      end
    end
    return cur;
  endfunction

  // Apply one transferred item to the shadow graph and return its result.
  function automatic result_t resolve_item(item_t it);
    result_t r;
    int      lim;
    r   = '0;
    lim = active_vertices();
    case (it.req)
      REQ_ARC: begin
        if (int'(it.a) >= lim || int'(it.b) >= lim) r.err = 1'b1;
        else adj_rows[it.a][it.b] = 1'b1;
      end
      REQ_STRONG: begin
        if (int'(it.a) >= lim) r.err = 1'b1;
        else r.mask = reach_set(it.a, lim, 1'b1, 1'b0) & reach_set(it.a, lim, 1'b0, 1'b1);
      end
      REQ_WEAK: begin
        if (int'(it.a) >= lim) r.err = 1'b1;
        else r.mask = reach_set(it.a, lim, 1'b1, 1'b1);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Arcs are kept mostly inside 8-vertex clusters and mostly pointing upward,
  // so components stay small for a good part of the run; rare back arcs close
  // cycles. At low counts most vertices are folded into range.
  function automatic item_t make_random_item();
    item_t it;
    int    r;
    int    base;
    int    x;
    int    y;
    int    lim;
    lim  = active_vertices();
    r    = $urandom_range(0, 99);
    base = $urandom_range(0, 3) * 8;
    x    = $urandom_range(0, 7);
    y    = $urandom_range(0, 7);
    it.b = vidx_t'($urandom_range(0, 31));
    if (r < 30) begin
      it.req = REQ_ARC;
      if (r < 2) begin
        it.a = vidx_t'($urandom_range(0, 31));
      end else if (r < 5) begin
        it.a = vidx_t'(base + ((x > y) ? x : y));
        it.b = vidx_t'(base + ((x > y) ? y : x));
      end else begin
        it.a = vidx_t'(base + ((x > y) ? y : x));
        it.b = vidx_t'(base + ((x > y) ? x : y));
      end
    end else if (r < 60) begin
      it.req = REQ_STRONG;
      it.a   = vidx_t'(base + x);
    end else if (r < 88) begin
      it.req = REQ_WEAK;
      it.a   = vidx_t'(base + x);
    end else if (r < 93) begin
      it.req = REQ_NONE;
      it.a   = vidx_t'($urandom_range(0, 31));
    end else begin
      case ($urandom_range(0, 2))
        0:       it.req = REQ_ARC;
        1:       it.req = REQ_STRONG;
        default: it.req = REQ_WEAK;
      endcase
      it.a = vidx_t'($urandom_range(0, 31));
    end
    if (lim > 0 && lim < MAX_VERTICES && $urandom_range(0, 9) != 0) begin
      it.a = vidx_t'(int'(it.a) % lim);
      it.b = vidx_t'(int'(it.b) % lim);
    end
    return it;
  endfunction

  function automatic void queue_item(req_t req, int a, int b);
    item_t it;
    it.req = req;
    it.a   = vidx_t'(a);
    it.b   = vidx_t'(b);
    add_pending(it);
  endfunction

  function automatic void queue_random(int count);
    for (int i = 0; i < count; i++) add_pending(make_random_item());
  endfunction

  // Hold until every queued item has been transferred and answered, then let
  // the block settle. Sample between edges so the driver's updates have landed.
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write vertex_count; only called while the block is idle.
  task automatic set_vertex_count(int value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CNT_W'(value);
    vert_count  = CNT_W'(value);
    cfg_writes++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Input driver: on a transfer, predict the result; when the slot is free,
  // either idle for the current gap or present the next pending item. Valid
  // stays high across back-to-back items.
  always @(posedge clk) begin
    item_t nxt;
    item_t cur;
    if (!rst_n) begin
      in_valid    <= 1'b0;
      tx_gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        cur.req = req_t'(in_req_type);
        cur.a   = in_vertex_a;
        cur.b   = in_vertex_b;
        add_expected(resolve_item(cur));
        case (cur.req)
          REQ_ARC:    cnt_arc++;
          REQ_STRONG: cnt_strong++;
          REQ_WEAK:   cnt_weak++;
          default:    cnt_unknown++;
        endcase
        if (expected_results[$].err) cnt_rejected++;
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap_left > 0) begin
          tx_gap_left <= tx_gap_left - 1;
          in_valid    <= 1'b0;
        end else if (pending_items.size() != 0) begin
          nxt = pending_items.pop_front();
          in_req_type <= nxt.req;
          in_vertex_a <= nxt.a;
          in_vertex_b <= nxt.b;
          in_valid    <= 1'b1;
          tx_gap_left <= tx_idle_on ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each transfer against the oldest prediction and
  // drive out_stall, with random stalls and the requested long hold.
  always @(posedge clk) begin
    result_t want;
    int      g;
    if (!rst_n) begin
      out_stall     <= 1'b0;
      rx_stall_left <= 0;
      rx_hold_left  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result: member_mask %h range_error %b",
                 out_member_mask, out_range_error);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_member_mask !== want.mask) begin
            $error("member_mask: expected %h, got %h", want.mask, out_member_mask);
            fail_count++;
          end
          if (out_range_error !== want.err) begin
            $error("range_error: expected %b, got %b", want.err, out_range_error);
            fail_count++;
          end
        end
      end
      if (hold_req != hold_ack) begin
        hold_ack     <= hold_req;
        rx_hold_left <= LONG_HOLD;
        out_stall    <= 1'b1;
      end else if (rx_hold_left > 0) begin
        rx_hold_left <= rx_hold_left - 1;
        out_stall    <= 1'b1;
      end else if (rx_stall_left > 0) begin
        rx_stall_left <= rx_stall_left - 1;
        out_stall     <= 1'b1;
      end else begin
        g = rx_idle_on ? pick_gap() : 0;
        rx_stall_left <= (g > 0) ? g - 1 : 0;
        out_stall     <= (g > 0);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL graph_component_finder");
      $finish;
    end
  end

  // Sequencer: reset, directed checks, then random phases at several counts.
  initial begin
    for (int v = 0; v < MAX_VERTICES; v++) adj_rows[v] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, count at its reset value: extreme vertices, duplicate arc,
    // self loop, an isolated vertex and the unknown request type.
    queue_item(REQ_ARC, 0, 31);
    queue_item(REQ_ARC, 31, 0);
    queue_item(REQ_ARC, 0, 31);
    queue_item(REQ_STRONG, 0, 0);
    queue_item(REQ_WEAK, 31, 31);
    queue_item(REQ_ARC, 5, 6);
    queue_item(REQ_STRONG, 5, 0);
    queue_item(REQ_WEAK, 6, 0);
    queue_item(REQ_NONE, 31, 31);
    queue_item(REQ_NONE, 0, 0);
    queue_item(REQ_WEAK, 10, 21);
    queue_item(REQ_ARC, 3, 3);
    queue_item(REQ_STRONG, 3, 0);
    wait_drained();

    // Count lowered after arcs exist: vertex 31 drops out of searches and
    // anything at or above the count is rejected.
    set_vertex_count(16);
    queue_item(REQ_ARC, 16, 0);
    queue_item(REQ_ARC, 0, 16);
    queue_item(REQ_STRONG, 16, 0);
    queue_item(REQ_WEAK, 31, 0);
    queue_item(REQ_STRONG, 0, 0);
    queue_item(REQ_WEAK, 5, 0);
    wait_drained();

    // Count zero rejects everything but the unknown type.
    set_vertex_count(0);
    queue_item(REQ_ARC, 0, 0);
    queue_item(REQ_STRONG, 0, 0);
    queue_item(REQ_NONE, 0, 0);
    wait_drained();

    // Count above capacity acts as the full vertex set.
    set_vertex_count(63);
    queue_item(REQ_STRONG, 31, 0);
    queue_item(REQ_WEAK, 0, 0);
    wait_drained();

    set_vertex_count(32);
    queue_random(180);
    wait_drained();

    // Back-pressure: receiver holds off for a long stretch while the sender
    // streams without gaps, so the block fills and stalls its input.
    tx_idle_on <= 1'b0;
    hold_req   <= ~hold_req;
    queue_random(40);
    wait_drained();

    // A stretch with no idling on either side at a small count.
    rx_idle_on <= 1'b0;
    set_vertex_count(12);
    queue_random(120);
    wait_drained();

    tx_idle_on <= 1'b1;
    rx_idle_on <= 1'b1;
    set_vertex_count(1);
    queue_random(30);
    wait_drained();

    set_vertex_count(40);
    queue_random(110);
    wait_drained();

    // Receiver-only idling at full size.
    tx_idle_on <= 1'b0;
    set_vertex_count(32);
    queue_random(200);
    wait_drained();

    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      fail_count++;
    end
    $display("Covered %0d transfers: %0d add-arc, %0d strong, %0d weak, %0d unknown, %0d rejected",
             cnt_arc + cnt_strong + cnt_weak + cnt_unknown, cnt_arc, cnt_strong, cnt_weak,
             cnt_unknown, cnt_rejected);
    $display("Checked %0d results over %0d vertex_count writes, one long receiver hold",
             results_seen, cfg_writes);
    if (fail_count == 0) begin
      $display("PASS graph_component_finder");
    end else begin
      $display("FAIL graph_component_finder");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/gcf_pkg.sv
hw/rtl/gcf_ram.sv
hw/rtl/gcf_dpath.sv
hw/rtl/gcf_ctrl.sv
hw/rtl/graph_component_finder.sv
bench/tb_graph_component_finder.sv
